>>> rtl/core/fpa_pkg.sv
// Shared constants and operation codes for the Q24.8 fixed-point ALU.
package fpa_pkg;

    localparam int FPA_FRAC_BITS = 8;
    localparam int FPA_WORD      = 32;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_TO_INT   = 4'd14,
        OP_FROM_INT = 4'd15
    } t_op;

endpackage

>>> rtl/core/fpa_delay.sv
// Fixed-length shift line that delays a word through DEPTH registers.
module fpa_delay import fpa_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) r_line[i] <= '0;
        end else begin
            r_line[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) r_line[i] <= r_line[i-1];
        end
    end

    assign o_data = r_line[DEPTH-1];

endmodule

>>> rtl/core/fpa_mul.sv
// Two-stage signed fixed-point multiplier, truncating toward zero.
module fpa_mul import fpa_pkg::*; #(
    parameter int FRAC_BITS = FPA_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic signed [FPA_WORD-1:0] i_a,
    input  logic signed [FPA_WORD-1:0] i_b,
    output logic        [FPA_WORD-1:0] o_prod
);

    localparam int PW = 2 * FPA_WORD;

    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] n_adj;
    logic        [FPA_WORD-1:0] r_res;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // bias negative products so the arithmetic shift truncates toward zero
    always_comb begin
        n_adj = r_prod;
        if (r_prod[PW-1]) n_adj = r_prod + PW'((64'd1 << FRAC_BITS) - 64'd1);
    end

    always_ff @(posedge i_clk) begin
        r_res <= FPA_WORD'(n_adj >>> FRAC_BITS);
    end

    assign o_prod = r_res;

endmodule

>>> rtl/core/fpa_div.sv
// Pipelined restoring divider, two quotient bits per stage.
module fpa_div import fpa_pkg::*; #(
    parameter int FRAC_BITS = FPA_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic signed [FPA_WORD-1:0] i_a,
    input  logic signed [FPA_WORD-1:0] i_b,
    output logic        [FPA_WORD-1:0] o_quot,
    output logic                       o_dz
);

    localparam int DW = FPA_WORD + FRAC_BITS;
    localparam int NS = (DW + 1) / 2;

    logic [FPA_WORD-1:0] r_rem [NS+1];
    logic [DW-1:0]       r_dq  [NS+1];
    logic [FPA_WORD-1:0] r_m   [NS+1];
    logic                r_neg [NS+1];
    logic                r_dz  [NS+1];
    logic [FPA_WORD-1:0] r_quot;
    logic                r_dzo;
    logic [FPA_WORD-1:0] abs_a;
    logic [FPA_WORD-1:0] abs_b;

    assign abs_a = i_a[FPA_WORD-1] ? FPA_WORD'(-i_a) : FPA_WORD'(i_a);
    assign abs_b = i_b[FPA_WORD-1] ? FPA_WORD'(-i_b) : FPA_WORD'(i_b);

    // prepare magnitudes and signs
    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_dq[0]  <= {abs_a, {FRAC_BITS{1'b0}}};
        r_m[0]   <= abs_b;
        r_neg[0] <= i_a[FPA_WORD-1] ^ i_b[FPA_WORD-1];
        r_dz[0]  <= (i_b == '0);
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [FPA_WORD-1:0] n_rem;
        logic [DW-1:0]       n_dq;

        always_comb begin : p_step
            logic [FPA_WORD:0] t;
            t     = '0;
            n_rem = r_rem[s];
            n_dq  = r_dq[s];
            for (int k = 0; k < 2; k++) begin
                if (s * 2 + k < DW) begin
                    t    = {n_rem, n_dq[DW-1]};
                    n_dq = {n_dq[DW-2:0], 1'b0};
                    if (t >= {1'b0, r_m[s]}) begin
                        t       = t - {1'b0, r_m[s]};
                        n_dq[0] = 1'b1;
                    end
                    n_rem = t[FPA_WORD-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= n_rem;
            r_dq[s+1]  <= n_dq;
            r_m[s+1]   <= r_m[s];
            r_neg[s+1] <= r_neg[s];
            r_dz[s+1]  <= r_dz[s];
        end
    end

    // apply sign, force zero on divide by zero
    always_ff @(posedge i_clk) begin
        if (r_dz[NS])       r_quot <= '0;
        else if (r_neg[NS]) r_quot <= FPA_WORD'(-r_dq[NS][FPA_WORD-1:0]);
        else                r_quot <= r_dq[NS][FPA_WORD-1:0];
        r_dzo <= r_dz[NS];
    end

    assign o_quot = r_quot;
    assign o_dz   = r_dzo;

endmodule

>>> rtl/core/fixed_point_q24_8_alu_core.sv
// Top level of the pipelined Q24.8 fixed-point ALU.
//
// Usage: present i_operation, i_operand_a and i_operand_b with start high;
// the transfer happens at the rising edge where start is high and busy is
// low. busy is low whenever reset is released, so a new transfer may be
// made in every cycle: throughput is one item per clock.
// Each result appears on o_result_value, o_compare_true and
// o_divide_by_zero for exactly one cycle, flagged by o_done, in the order
// the items went in. The receiver cannot stall; results must be taken.
// Every operation takes the same path: the input register, then the
// divider's prepare stage, its quotient stages and its sign stage (or
// delay lines that match them), then the output register. The divider
// resolves two quotient bits per stage; the other paths are delayed to
// line up with it. Multiply uses a registered 32x32 product and a registered result.
// Synchronous active-low reset clears all valid bits, so nothing is
// emitted for items in flight when reset is asserted; busy is high
// throughout reset.
module fixed_point_q24_8_alu_core import fpa_pkg::*; #(
    parameter int FRAC_BITS = FPA_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic        [3:0]          i_operation,
    input  logic signed [FPA_WORD-1:0] i_operand_a,
    input  logic signed [FPA_WORD-1:0] i_operand_b,
    output logic                       o_done,
    output logic signed [FPA_WORD-1:0] o_result_value,
    output logic                       o_compare_true,
    output logic                       o_divide_by_zero
);

    localparam int DW      = FPA_WORD + FRAC_BITS;
    localparam int NS      = (DW + 1) / 2;
    localparam int DIV_LAT = NS + 2;
    localparam int SW      = 1 + 4 + FPA_WORD + 1;

    // input stage
    logic                       r_vld;
    t_op                        r_op;
    logic signed [FPA_WORD-1:0] r_a;
    logic signed [FPA_WORD-1:0] r_b;

    logic [FPA_WORD-1:0] n_val;
    logic                n_flag;
    logic [FPA_WORD-1:0] mul_res;
    logic [FPA_WORD-1:0] mul_dly;
    logic [FPA_WORD-1:0] div_res;
    logic                div_dz;
    logic [SW-1:0]       side_dly;
    logic                d_vld;
    t_op                 d_op;
    logic [FPA_WORD-1:0] d_val;
    logic                d_flag;

    logic                r_done;
    logic [FPA_WORD-1:0] r_res;
    logic                r_cmp;
    logic                r_dz;

    assign busy = !i_rst_n;

    // capture the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start && !busy;
        end
        r_op <= t_op'(i_operation);
        r_a  <= i_operand_a;
        r_b  <= i_operand_b;
    end

    // short-path operations, worked out combinationally from the input stage
    always_comb begin
        n_val  = '0;
        n_flag = 1'b0;
        case (r_op)
            OP_ADD:      n_val  = FPA_WORD'(r_a + r_b);
            OP_SUB:      n_val  = FPA_WORD'(r_a - r_b);
            OP_GT:       n_flag = r_a > r_b;
            OP_LT:       n_flag = r_a < r_b;
            OP_GE:       n_flag = r_a >= r_b;
            OP_LE:       n_flag = r_a <= r_b;
            OP_EQ:       n_flag = r_a == r_b;
            OP_NE:       n_flag = r_a != r_b;
            OP_MIN:      n_val  = (r_a > r_b) ? r_b : r_a;
            OP_MAX:      n_val  = (r_a < r_b) ? r_b : r_a;
            OP_INC:      n_val  = FPA_WORD'(r_a + 32'sd1);
            OP_DEC:      n_val  = FPA_WORD'(r_a - 32'sd1);
            OP_TO_INT:   n_val  = FPA_WORD'(r_a >>> FRAC_BITS);
            OP_FROM_INT: n_val  = FPA_WORD'(r_a << FRAC_BITS);
            default:     n_val  = '0;
        endcase
    end

    fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk  (i_clk),
        .i_a    (r_a),
        .i_b    (r_b),
        .o_prod (mul_res)
    );

    // line the product up with the divider output
    fpa_delay #(.WIDTH(FPA_WORD), .DEPTH(DIV_LAT - 2)) u_mul_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (mul_res),
        .o_data  (mul_dly)
    );

    fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_a    (r_a),
        .i_b    (r_b),
        .o_quot (div_res),
        .o_dz   (div_dz)
    );

    // carry valid, opcode and the short-path result alongside the divider
    fpa_delay #(.WIDTH(SW), .DEPTH(DIV_LAT)) u_side_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  ({r_vld, r_op, n_val, n_flag}),
        .o_data  (side_dly)
    );

    assign d_vld  = side_dly[SW-1];
    assign d_op   = t_op'(side_dly[SW-2 -: 4]);
    assign d_val  = side_dly[FPA_WORD:1];
    assign d_flag = side_dly[0];

    // merge the paths into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d_vld;
        end
        case (d_op)
            OP_MUL: begin
                r_res <= mul_dly;
                r_cmp <= 1'b0;
                r_dz  <= 1'b0;
            end
            OP_DIV: begin
                r_res <= div_res;
                r_cmp <= 1'b0;
                r_dz  <= div_dz;
            end
            default: begin
                r_res <= d_val;
                r_cmp <= d_flag;
                r_dz  <= 1'b0;
            end
        endcase
    end

    assign o_done           = r_done;
    assign o_result_value   = r_res;
    assign o_compare_true   = r_cmp;
    assign o_divide_by_zero = r_dz;

endmodule
